// ===== hw/rtl/weighted_lane_queue_scheduler_defines.svh =====
// Assertion macros for the weighted lane queue scheduler
`ifndef WEIGHTED_LANE_QUEUE_SCHEDULER_DEFINES_SVH
`define WEIGHTED_LANE_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, held off during reset
`define WLQS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlqs same-cycle check failed");

// next-cycle implication, held off during reset
`define WLQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlqs next-cycle check failed");

`endif

// ===== hw/rtl/wlqs_pkg.sv =====
// Shared constants, types and schedule function of the weighted lane queue scheduler
package wlqs_pkg;

    localparam int NUM_LANES      = 4;
    localparam int LANE_BITS      = $clog2(NUM_LANES);
    localparam int LANE_DEPTH     = 16;
    localparam int IDX_BITS       = $clog2(LANE_DEPTH);
    localparam int FILL_BITS      = $clog2(LANE_DEPTH + 1);
    localparam int ADDR_BITS      = LANE_BITS + IDX_BITS;
    localparam int PAYLOAD_BITS   = 32;
    localparam int SCHEDULE_SLOTS = 15;
    localparam int SLOT_BITS      = $clog2(SCHEDULE_SLOTS);
    localparam int STATUS_BITS    = 3;
    localparam int POLICY_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 5;

    localparam int LANE0_SLOT_END = 8;
    localparam int LANE1_SLOT_END = 12;
    localparam int LANE2_SLOT_END = 14;

    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED             = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED_DROP_OLDEST = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_DROPPED_NEWEST       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_REJECTED             = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_POPPED               = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_ALL_EMPTY            = 3'd5;

    localparam logic [POLICY_BITS-1:0] POL_DROP_OLDEST = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_DROP_NEWEST = 2'd1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY_BASE = 3'd4;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_data;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
    } sts_t;

    function automatic logic [LANE_BITS-1:0] slot_lane(input logic [SLOT_BITS-1:0] slot);
        logic [LANE_BITS-1:0] l;
        if (int'(slot) < LANE0_SLOT_END)
            l = LANE_BITS'(0);
        else if (int'(slot) < LANE1_SLOT_END)
            l = LANE_BITS'(1);
        else if (int'(slot) < LANE2_SLOT_END)
            l = LANE_BITS'(2);
        else
            l = LANE_BITS'(3);
        return l;
    endfunction

endpackage

// ===== hw/rtl/wlqs_ctrl.sv =====
// Controller state machine sequencing one item through the datapath
module wlqs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  wlqs_pkg::sts_t sts,
    output wlqs_pkg::cmd_t cmd
);
    import wlqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_data = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_pop ? S_READ : S_OUT;
            end
            S_READ:
            begin
                cmd.load_data = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

// ===== hw/rtl/wlqs_datapath.sv =====
// Lane queues, payload memory, calendar scan and result registers
module wlqs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wlqs_pkg::cmd_t                       cmd,
    output wlqs_pkg::sts_t                       sts,
    input  logic                                 cfg_we,
    input  logic [wlqs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wlqs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 operation,
    input  logic [wlqs_pkg::LANE_BITS-1:0]       lane,
    input  logic [wlqs_pkg::PAYLOAD_BITS-1:0]    payload,
    output logic [wlqs_pkg::STATUS_BITS-1:0]     status,
    output logic [wlqs_pkg::LANE_BITS-1:0]       served_lane,
    output logic [wlqs_pkg::PAYLOAD_BITS-1:0]    popped_payload,
    output logic [wlqs_pkg::FILL_BITS-1:0]       lane_depth
);
    import wlqs_pkg::*;

    logic [CFG_DATA_BITS-1:0]  cap_reg  [NUM_LANES];
    logic [POLICY_BITS-1:0]    pol_reg  [NUM_LANES];
    logic [IDX_BITS-1:0]       head_reg [NUM_LANES];
    logic [IDX_BITS-1:0]       head_next[NUM_LANES];
    logic [IDX_BITS-1:0]       tail_reg [NUM_LANES];
    logic [IDX_BITS-1:0]       tail_next[NUM_LANES];
    logic [FILL_BITS-1:0]      fill_reg [NUM_LANES];
    logic [FILL_BITS-1:0]      fill_next[NUM_LANES];
    logic [SLOT_BITS-1:0]      cursor_reg;
    logic [SLOT_BITS-1:0]      cursor_next;

    logic                      op_reg;
    logic [LANE_BITS-1:0]      lane_reg;
    logic [PAYLOAD_BITS-1:0]   payload_reg;

    logic [STATUS_BITS-1:0]    status_reg,  status_next;
    logic [LANE_BITS-1:0]      served_reg,  served_next;
    logic [FILL_BITS-1:0]      depth_reg,   depth_next;
    logic [PAYLOAD_BITS-1:0]   popped_reg;
    logic                      hit_reg,     hit_next;

    logic [PAYLOAD_BITS-1:0]   store_mem [NUM_LANES * LANE_DEPTH];
    logic [PAYLOAD_BITS-1:0]   mem_q_reg;
    logic                      mem_we;
    logic [ADDR_BITS-1:0]      wr_addr;
    logic [ADDR_BITS-1:0]      rd_addr;

    logic [SCHEDULE_SLOTS-1:0] nonempty;
    logic [SLOT_BITS-1:0]      slot_at [SCHEDULE_SLOTS];
    logic [SLOT_BITS:0]        slot_sum[SCHEDULE_SLOTS];
    logic                      found;
    logic [SLOT_BITS-1:0]      pick_slot;
    logic [LANE_BITS-1:0]      pick_lane;

    logic [CFG_DATA_BITS-1:0]  cap_raw;
    logic [FILL_BITS-1:0]      cap_eff;
    logic [FILL_BITS-1:0]      push_fill;
    logic                      lane_full;

    assign sts.is_pop = (op_reg == OP_POP);

    // calendar scan from the cursor
    always_comb
    begin
        for (int s = 0; s < SCHEDULE_SLOTS; s++)
            nonempty[s] = (fill_reg[slot_lane(SLOT_BITS'(s))] != '0);
        for (int k = 0; k < SCHEDULE_SLOTS; k++)
        begin
            slot_sum[k] = {1'b0, cursor_reg} + (SLOT_BITS + 1)'(k);
            if (slot_sum[k] >= (SLOT_BITS + 1)'(SCHEDULE_SLOTS))
                slot_sum[k] = slot_sum[k] - (SLOT_BITS + 1)'(SCHEDULE_SLOTS);
            slot_at[k] = slot_sum[k][SLOT_BITS-1:0];
        end
        found     = 1'b0;
        pick_slot = '0;
        for (int k = 0; k < SCHEDULE_SLOTS; k++)
        begin
            if (!found && nonempty[slot_at[k]])
            begin
                found     = 1'b1;
                pick_slot = slot_at[k];
            end
        end
        pick_lane = slot_lane(pick_slot);
    end

    // effective capacity of the push lane
    always_comb
    begin
        cap_raw = cap_reg[lane_reg];
        if (cap_raw == '0)
            cap_eff = FILL_BITS'(1);
        else if (cap_raw > CFG_DATA_BITS'(LANE_DEPTH))
            cap_eff = FILL_BITS'(LANE_DEPTH);
        else
            cap_eff = FILL_BITS'(cap_raw);
        push_fill = fill_reg[lane_reg];
        lane_full = (push_fill >= cap_eff);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            fill_next[i] = fill_reg[i];
        end
        cursor_next = cursor_reg;
        status_next = status_reg;
        served_next = served_reg;
        depth_next  = depth_reg;
        hit_next    = hit_reg;
        mem_we      = 1'b0;
        wr_addr     = {lane_reg, tail_reg[lane_reg]};
        rd_addr     = {pick_lane, head_reg[pick_lane]};
        if (cmd.exec)
        begin
            if (op_reg == OP_PUSH)
            begin
                served_next = lane_reg;
                hit_next    = 1'b0;
                depth_next  = push_fill;
                if (!lane_full)
                begin
                    mem_we              = 1'b1;
                    tail_next[lane_reg] = tail_reg[lane_reg] + IDX_BITS'(1);
                    fill_next[lane_reg] = push_fill + FILL_BITS'(1);
                    depth_next          = push_fill + FILL_BITS'(1);
                    status_next         = ST_ACCEPTED;
                end
                else if (pol_reg[lane_reg] == POL_DROP_OLDEST)
                begin
                    mem_we              = 1'b1;
                    head_next[lane_reg] = head_reg[lane_reg] + IDX_BITS'(1);
                    tail_next[lane_reg] = tail_reg[lane_reg] + IDX_BITS'(1);
                    status_next         = ST_ACCEPTED_DROP_OLDEST;
                end
                else if (pol_reg[lane_reg] == POL_DROP_NEWEST)
                    status_next = ST_DROPPED_NEWEST;
                else
                    status_next = ST_REJECTED;
            end
            else if (found)
            begin
                head_next[pick_lane] = head_reg[pick_lane] + IDX_BITS'(1);
                fill_next[pick_lane] = fill_reg[pick_lane] - FILL_BITS'(1);
                cursor_next = (pick_slot == SLOT_BITS'(SCHEDULE_SLOTS - 1))
                              ? '0 : pick_slot + SLOT_BITS'(1);
                status_next = ST_POPPED;
                served_next = pick_lane;
                depth_next  = fill_reg[pick_lane] - FILL_BITS'(1);
                hit_next    = 1'b1;
            end
            else
            begin
                status_next = ST_ALL_EMPTY;
                served_next = '0;
                depth_next  = '0;
                hit_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                cap_reg[i]  <= CFG_DATA_BITS'(LANE_DEPTH);
                pol_reg[i]  <= POL_DROP_OLDEST;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            cursor_reg <= '0;
            op_reg     <= OP_PUSH;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < CFG_POLICY_BASE)
                    cap_reg[cfg_index[LANE_BITS-1:0]] <= cfg_data;
                else
                    pol_reg[cfg_index[LANE_BITS-1:0]] <= cfg_data[POLICY_BITS-1:0];
            end
            for (int i = 0; i < NUM_LANES; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                fill_reg[i] <= fill_next[i];
            end
            cursor_reg <= cursor_next;
            if (cmd.capture)
                op_reg <= operation;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lane_reg    <= lane;
            payload_reg <= payload;
        end
        status_reg <= status_next;
        served_reg <= served_next;
        depth_reg  <= depth_next;
        hit_reg    <= hit_next;
        if (cmd.exec && op_reg == OP_PUSH)
            popped_reg <= '0;
        else if (cmd.load_data)
            popped_reg <= hit_reg ? mem_q_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wr_addr] <= payload_reg;
        if (cmd.exec)
            mem_q_reg <= store_mem[rd_addr];
    end

    assign status         = status_reg;
    assign served_lane    = served_reg;
    assign popped_payload = popped_reg;
    assign lane_depth     = depth_reg;

endmodule

// ===== hw/rtl/weighted_lane_queue_scheduler.sv =====
// Top level of the weighted lane queue scheduler
//
// Input channel (in_valid/in_stall): operation, lane and payload. A push
// stores payload in the named lane, applying the lane's overflow policy when
// it is full; a pop serves the first non-empty lane found on the 15-slot
// calendar starting at the saved cursor (8/4/2/1 slots for lanes 0..3).
// Output channel (out_valid/out_stall): one result per item with status,
// served_lane, popped_payload and lane_depth.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..3 lane
// capacities, 4..7 lane overflow policies); write only while idle.
// Sequencing: a push goes from IDLE through EXEC to OUT, a pop through EXEC,
// READ and OUT, since the payload comes through a registered memory read.
// The controller handles one item from transfer to result transfer, so no new
// item is taken until the last result has been transferred (in_stall is high).
// Reset: all lanes empty, cursor at slot 0, capacities 16, policies drop
// oldest. While the receiver stalls, the result holds and in_stall stays high.
module weighted_lane_queue_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wlqs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wlqs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [wlqs_pkg::LANE_BITS-1:0]       lane,
    input  logic [wlqs_pkg::PAYLOAD_BITS-1:0]    payload,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wlqs_pkg::STATUS_BITS-1:0]     status,
    output logic [wlqs_pkg::LANE_BITS-1:0]       served_lane,
    output logic [wlqs_pkg::PAYLOAD_BITS-1:0]    popped_payload,
    output logic [wlqs_pkg::FILL_BITS-1:0]       lane_depth
);
    import wlqs_pkg::*;

`include "weighted_lane_queue_scheduler_defines.svh"

    cmd_t cmd;
    sts_t sts;

    wlqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wlqs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .lane           (lane),
        .payload        (payload),
        .status         (status),
        .served_lane    (served_lane),
        .popped_payload (popped_payload),
        .lane_depth     (lane_depth)
    );

    `WLQS_ASSERT_IMPLY(a_one_item, clk, rst_n, out_valid, in_stall)
    `WLQS_ASSERT_NEXT(a_no_bypass, clk, rst_n, in_valid && !in_stall, !out_valid)
    `WLQS_ASSERT_IMPLY(a_empty_result, clk, rst_n, out_valid && status == ST_ALL_EMPTY,
        popped_payload == '0 && lane_depth == '0 && served_lane == '0)
    `WLQS_ASSERT_IMPLY(a_push_depth, clk, rst_n,
        out_valid && (status == ST_ACCEPTED || status == ST_ACCEPTED_DROP_OLDEST),
        lane_depth != '0 && popped_payload == '0)

endmodule
